@@ rtl/core/exlex_pkg.sv @@
// ----------------------------------------------------------------------------
// exlex_pkg
// Shared types and codes for the expression lexer with unary-minus detection.
// ----------------------------------------------------------------------------
package exlex_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NAME   = 3'd1,
        MODE_DOLLAR = 3'd2,
        MODE_VAR    = 3'd3,
        MODE_INT    = 3'd4,
        MODE_DOT    = 3'd5,
        MODE_FRAC   = 3'd6
    } lex_mode_t;

    typedef logic [3:0] char_class_t;
    typedef logic [1:0] err_code_t;

    localparam char_class_t CLS_SPACE    = 4'd0;
    localparam char_class_t CLS_NAME     = 4'd1;
    localparam char_class_t CLS_ASSIGN   = 4'd2;
    localparam char_class_t CLS_VAR      = 4'd3;
    localparam char_class_t CLS_NUM      = 4'd4;
    localparam char_class_t CLS_BINOP    = 4'd5;
    localparam char_class_t CLS_UMINUS   = 4'd6;
    localparam char_class_t CLS_OPEN     = 4'd7;
    localparam char_class_t CLS_CLOSE    = 4'd8;
    localparam char_class_t CLS_EQUALS   = 4'd9;

    localparam err_code_t ERR_NONE  = 2'd0;
    localparam err_code_t ERR_INPUT = 2'd1;
    localparam err_code_t ERR_UNARY = 2'd2;

    typedef struct packed {
        lex_mode_t mode;
        logic      unary_pos;
        logic      input_error;
        logic      unary_error;
    } lex_state_t;

    localparam lex_state_t LEX_STATE_RESET = '{
        mode:        MODE_IDLE,
        unary_pos:   1'b1,
        input_error: 1'b0,
        unary_error: 1'b0
    };

    typedef struct packed {
        char_class_t char_class;
        logic        token_start;
        err_code_t   error_code;
    } lex_result_t;

endpackage

@@ rtl/core/expression_lexer_unary_minus.sv @@
// ----------------------------------------------------------------------------
// expression_lexer_unary_minus
// Streaming calculator-expression lexer: one result word per input character.
// ----------------------------------------------------------------------------
// Path: input register, then classifier, then result register.
// Throughput: 1 word per cycle unless the output stalls; the lexer state
// loop is one pass of the classifier between the input and result registers.
// Reset: rst_n clears valids and lexer state (idle, unary position set,
// no errors); state also returns to reset after each last character.
module expression_lexer_unary_minus
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // last_char

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] char_class, [4] token_start,
                                       // [6:5] error_code, [7] zero
    output logic       m_axis_tlast    // end_flag
);
    import exlex_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    lex_result_t out_result_reg;
    logic        out_last_reg;

    lex_state_t  state_reg;
    lex_state_t  state_next;
    lex_result_t result;

    logic        in_take;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    exlex_classify u_classify
    (
        .ch         (in_ch_reg),
        .last_char  (in_last_reg),
        .state      (state_reg),
        .result     (result),
        .state_next (state_next)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_result_reg <= result;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg.error_code, out_result_reg.token_start,
                            out_result_reg.char_class};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/core/exlex_classify.sv @@
// ----------------------------------------------------------------------------
// exlex_classify
// Classifies one character against the current lexer state and returns the
// result word fields together with the following state.
// ----------------------------------------------------------------------------
module exlex_classify
(
    input  logic [7:0]              ch,
    input  logic                    last_char,
    input  exlex_pkg::lex_state_t   state,
    output exlex_pkg::lex_result_t  result,
    output exlex_pkg::lex_state_t   state_next
);
    import exlex_pkg::*;

    logic        is_letter;
    logic        is_digit;
    logic        fresh;
    char_class_t cls;
    logic        start;
    lex_state_t  upd;
    err_code_t   err;

    assign is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);

    always_comb
    begin
        upd   = state;
        cls   = CLS_SPACE;
        start = 1'b0;
        fresh = 1'b0;

        unique case (state.mode)
            MODE_NAME:
            begin
                if (is_letter)
                begin
                    cls = CLS_NAME;
                end
                else if (ch == "=")
                begin
                    cls      = CLS_ASSIGN;
                    upd.mode = MODE_IDLE;
                end
                else
                begin
                    upd.input_error = 1'b1;
                    fresh           = 1'b1;
                end
            end
            MODE_DOLLAR:
            begin
                if (is_letter)
                begin
                    cls           = CLS_VAR;
                    upd.mode      = MODE_VAR;
                    upd.unary_pos = 1'b0;
                end
                else
                begin
                    upd.input_error = 1'b1;
                    fresh           = 1'b1;
                end
            end
            MODE_VAR:
            begin
                if (is_letter)
                    cls = CLS_VAR;
                else
                    fresh = 1'b1;
            end
            MODE_INT:
            begin
                if (is_digit)
                begin
                    cls = CLS_NUM;
                end
                else if (ch == ".")
                begin
                    cls      = CLS_NUM;
                    upd.mode = MODE_DOT;
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
            MODE_DOT:
            begin
                if (is_digit)
                begin
                    cls      = CLS_NUM;
                    upd.mode = MODE_FRAC;
                end
                else
                begin
                    upd.input_error = 1'b1;
                    fresh           = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (is_digit)
                    cls = CLS_NUM;
                else
                    fresh = 1'b1;
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        if (fresh)
        begin
            upd.mode = MODE_IDLE;
            start    = 1'b1;
            if (is_letter)
            begin
                cls      = CLS_NAME;
                upd.mode = MODE_NAME;
            end
            else if (is_digit)
            begin
                cls           = CLS_NUM;
                upd.mode      = MODE_INT;
                upd.unary_pos = 1'b0;
            end
            else if (ch == "$")
            begin
                cls      = CLS_VAR;
                upd.mode = MODE_DOLLAR;
            end
            else if (ch == "-")
            begin
                if (upd.unary_pos)
                begin
                    cls = CLS_UMINUS;
                end
                else
                begin
                    cls           = CLS_BINOP;
                    upd.unary_pos = 1'b1;
                end
            end
            else if ((ch == "+") || (ch == "*") || (ch == "/") || (ch == "^"))
            begin
                cls = CLS_BINOP;
                if (upd.unary_pos)
                    upd.unary_error = 1'b1;
                upd.unary_pos = 1'b1;
            end
            else if (ch == "=")
            begin
                cls           = CLS_EQUALS;
                upd.unary_pos = 1'b0;
            end
            else if (ch == "(")
            begin
                cls = CLS_OPEN;
            end
            else if (ch == ")")
            begin
                cls           = CLS_CLOSE;
                upd.unary_pos = 1'b0;
            end
            else
            begin
                cls   = CLS_SPACE;
                start = 1'b0;
                if (ch != " ")
                    upd.input_error = 1'b1;
            end
        end

        // open name run, '$' or '.' at end of expression
        if (last_char && ((upd.mode == MODE_NAME) || (upd.mode == MODE_DOLLAR) ||
                          (upd.mode == MODE_DOT)))
            upd.input_error = 1'b1;

        if (upd.input_error)
            err = ERR_INPUT;
        else if (upd.unary_error)
            err = ERR_UNARY;
        else
            err = ERR_NONE;
    end

    assign result.char_class  = cls;
    assign result.token_start = start;
    assign result.error_code  = err;

    assign state_next = last_char ? LEX_STATE_RESET : upd;

endmodule

@@ sim/tb_expression_lexer_unary_minus.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expression_lexer_unary_minus
// Streams expressions one character word at a time through the lexer. A
// short table covers the edge cases, then random expressions follow: mostly
// well-formed, some corrupted, some raw noise. An in-bench classifier
// predicts unfixed result words, and the run varies idling on both sides.
// ----------------------------------------------------------------------------
module tb_expression_lexer_unary_minus;

    import exlex_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_CHARS    = 95;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic        last;
        err_code_t   err;
        logic        start;
        char_class_t cls;
    } lex_word_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        fixed;
        char_class_t cls;
        logic        start;
        err_code_t   err;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatches = 0;
    int         words_out = 0;

    lex_state_t lex_st = LEX_STATE_RESET;
    lex_word_t  expected_q[$];
    logic [7:0] text_q[$];

    // typed expectations only where they are obvious; zeros elsewhere
    localparam int DIR_ROWS = 27;
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_INPUT},
        '{8'hFF, 1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_INPUT},
        '{" ",   1'b1, 1'b1, CLS_SPACE,  1'b0, ERR_NONE},
        '{"-",   1'b0, 1'b1, CLS_UMINUS, 1'b1, ERR_NONE},
        '{"(",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"9",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{".",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"0",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{")",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"-",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"$",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"v",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"^",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"+",   1'b1, 1'b1, CLS_BINOP,  1'b1, ERR_UNARY},
        '{"a",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"=",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"=",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"q",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"1",   1'b1, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"$",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"7",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{".",   1'b1, 1'b1, CLS_NUM,    1'b0, ERR_INPUT},
        '{"*",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"Z",   1'b1, 1'b1, CLS_NAME,   1'b1, ERR_INPUT},
        '{"8",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{".",   1'b0, 1'b0, CLS_SPACE,  1'b0, ERR_NONE},
        '{"x",   1'b1, 1'b0, CLS_SPACE,  1'b0, ERR_NONE}
    };

    expression_lexer_unary_minus dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Lexer state machine; advances lex_st by one character.
    function automatic lex_word_t classify_char(input logic [7:0] c, input logic last);
        lex_word_t w;
        logic      fresh;
        w     = '0;
        fresh = 1'b0;
        case (lex_st.mode)
            MODE_NAME:
            begin
                if (is_alpha(c))
                    w.cls = CLS_NAME;
                else if (c == "=")
                begin
                    w.cls       = CLS_ASSIGN;
                    lex_st.mode = MODE_IDLE;
                end
                else
                begin
                    lex_st.input_error = 1'b1;
                    fresh              = 1'b1;
                end
            end
            MODE_DOLLAR:
            begin
                if (is_alpha(c))
                begin
                    w.cls            = CLS_VAR;
                    lex_st.mode      = MODE_VAR;
                    lex_st.unary_pos = 1'b0;
                end
                else
                begin
                    lex_st.input_error = 1'b1;
                    fresh              = 1'b1;
                end
            end
            MODE_VAR:
            begin
                if (is_alpha(c))
                    w.cls = CLS_VAR;
                else
                    fresh = 1'b1;
            end
            MODE_INT:
            begin
                if (is_num(c))
                    w.cls = CLS_NUM;
                else if (c == ".")
                begin
                    w.cls       = CLS_NUM;
                    lex_st.mode = MODE_DOT;
                end
                else
                    fresh = 1'b1;
            end
            MODE_DOT:
            begin
                if (is_num(c))
                begin
                    w.cls       = CLS_NUM;
                    lex_st.mode = MODE_FRAC;
                end
                else
                begin
                    lex_st.input_error = 1'b1;
                    fresh              = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (is_num(c))
                    w.cls = CLS_NUM;
                else
                    fresh = 1'b1;
            end
            default:
                fresh = 1'b1;
        endcase

        if (fresh)
        begin
            lex_st.mode = MODE_IDLE;
            w.start     = 1'b1;
            if (is_alpha(c))
            begin
                w.cls       = CLS_NAME;
                lex_st.mode = MODE_NAME;
            end
            else if (is_num(c))
            begin
                w.cls            = CLS_NUM;
                lex_st.mode      = MODE_INT;
                lex_st.unary_pos = 1'b0;
            end
            else if (c == "$")
            begin
                w.cls       = CLS_VAR;
                lex_st.mode = MODE_DOLLAR;
            end
            else if (c == "-")
            begin
                if (lex_st.unary_pos)
                    w.cls = CLS_UMINUS;
                else
                begin
                    w.cls            = CLS_BINOP;
                    lex_st.unary_pos = 1'b1;
                end
            end
            else if (c == "+" || c == "*" || c == "/" || c == "^")
            begin
                w.cls = CLS_BINOP;
                if (lex_st.unary_pos)
                    lex_st.unary_error = 1'b1;
                lex_st.unary_pos = 1'b1;
            end
            else if (c == "=")
            begin
                w.cls            = CLS_EQUALS;
                lex_st.unary_pos = 1'b0;
            end
            else if (c == "(")
                w.cls = CLS_OPEN;
            else if (c == ")")
            begin
                w.cls            = CLS_CLOSE;
                lex_st.unary_pos = 1'b0;
            end
            else
            begin
                w.cls   = CLS_SPACE;
                w.start = 1'b0;
                if (c != " ")
                    lex_st.input_error = 1'b1;
            end
        end

        if (last && (lex_st.mode == MODE_NAME || lex_st.mode == MODE_DOLLAR ||
                     lex_st.mode == MODE_DOT))
            lex_st.input_error = 1'b1;

        w.err  = lex_st.input_error ? ERR_INPUT : (lex_st.unary_error ? ERR_UNARY : ERR_NONE);
        w.last = last;
        if (last)
            lex_st = LEX_STATE_RESET;
        return w;
    endfunction

    function automatic void put_char(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
            return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_op(input logic with_eq);
        case ($urandom_range(with_eq ? 5 : 4))
            0:       return "+";
            1:       return "-";
            2:       return "*";
            3:       return "/";
            4:       return "^";
            default: return "=";
        endcase
    endfunction

    function automatic void add_operand(input int depth);
        int n;
        if ($urandom_range(3) == 0)
            put_char("-");
        case ($urandom_range(depth < 2 ? 3 : 2))
            2:
            begin
                put_char("$");
                n = $urandom_range(1, 3);
                repeat (n) put_char(rand_letter());
            end
            3:
            begin
                put_char("(");
                add_expr(depth + 1);
                put_char(")");
            end
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n) put_char(rand_digit());
                if ($urandom_range(2) == 0)
                begin
                    put_char(".");
                    n = $urandom_range(1, 2);
                    repeat (n) put_char(rand_digit());
                end
            end
        endcase
    endfunction

    function automatic void add_expr(input int depth);
        int n;
        n = $urandom_range(3);
        add_operand(depth);
        repeat (n)
        begin
            if ($urandom_range(5) == 0)
                put_char(" ");
            put_char(rand_op($urandom_range(9) == 0));
            if ($urandom_range(5) == 0)
                put_char(" ");
            add_operand(depth);
        end
    endfunction

    // Mostly well-formed expressions, some corrupted, a few pure noise.
    function automatic void build_expression();
        int r;
        int n;
        int pos;
        text_q.delete();
        r = $urandom_range(99);
        if (r < 6)
        begin
            n = $urandom_range(1, 6);
            repeat (n) put_char(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(1, 4);
            repeat (n) put_char(rand_letter());
            put_char("=");
        end
        add_expr(0);
        if (r < 30)
        begin
            pos = $urandom_range(text_q.size() - 1);
            case ($urandom_range(3))
                0: text_q[pos] = 8'($urandom_range(255));
                1: text_q = text_q[0:pos];
                2: text_q.insert(pos, rand_op(1'b0));
                default: text_q.insert(pos, ($urandom_range(1) == 0) ? 8'h2E : 8'h24);
            endcase
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic fixed, input lex_word_t fixed_word);
        lex_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        w = classify_char(c, last);
        expected_q.insert(expected_q.size(), fixed ? fixed_word : w);
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        lex_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("word %0d: unexpected result tdata=%h tlast=%b",
                             words_out, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[3:0] !== want.cls || m_axis_tdata[4] !== want.start ||
                    m_axis_tdata[6:5] !== want.err || m_axis_tdata[7] !== 1'b0 ||
                    m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("word %0d: expected cls=%0d start=%b err=%0d end=%b,",
                               words_out, want.cls, want.start, want.err, want.last);
                        $display(" got cls=%0d start=%b err=%0d pad=%b end=%b",
                                 m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[6:5],
                                 m_axis_tdata[7], m_axis_tlast);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int        sent;
        lex_word_t fw;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            fw = '{last: dir_tab[i].last, err: dir_tab[i].err,
                   start: dir_tab[i].start, cls: dir_tab[i].cls};
            send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].fixed, fw);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            // hold off until the pipeline has drained
            if (ph == 2)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            sent = 0;
            while (sent < PHASE_CHARS)
            begin
                build_expression();
                foreach (text_q[j])
                    send_char(text_q[j], j == text_q.size() - 1, 1'b0, '0);
                sent += text_q.size();
            end
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
        repeat (6) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
